/* rtl/core/rpp_pkg.sv */
`timescale 1ns / 1ps
package rpp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int N_ITER        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int ITER_W        = $clog2(TABLE_LEN);

  // rotator datapath widths
  localparam int VW = 33;   // difference vector entering a rotator
  localparam int XW = 36;   // rotator working width
  localparam int ZW = 32;   // residual angle, 2^32 per turn
  localparam int MW = 38;   // sum of three rotated vectors

  localparam logic signed [24:0] GAIN_Q24 = 25'sd10188014;

  // prescale stage + quadrant stage + iteration cells
  localparam int ROT_LAT = N_ITER + 2;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X     = 8'd0,
    REG_CAMERA_Y     = 8'd1,
    REG_CAMERA_ANGLE = 8'd2,
    REG_MARKER_X     = 8'd3,
    REG_MARKER_Y     = 8'd4,
    REG_MARKER_ANGLE = 8'd5,
    REG_VIS_RADIUS   = 8'd6,
    REG_TARGET_AGENT = 8'd7
  } reg_idx_t;

  typedef logic [ITER_W-1:0] iter_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic signed [ZW-1:0] atan_lut(input iter_t i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10680862;
      5'd7:  v = 32'sd5341269;
      5'd8:  v = 32'sd2670675;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41721;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/rpp_in_if.sv */
`timescale 1ns / 1ps
interface rpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] source_x;
  logic signed [31:0] source_y;
  logic signed [15:0] source_angle;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [15:0] target_angle;
  logic signed [31:0] noise_x;
  logic signed [31:0] noise_y;
  logic signed [15:0] noise_angle;

  modport source (output valid, source_x, source_y, source_angle, target_x, target_y,
                  target_angle, noise_x, noise_y, noise_angle, input ready);
  modport sink (input valid, source_x, source_y, source_angle, target_x, target_y,
                target_angle, noise_x, noise_y, noise_angle, output ready);
endinterface

/* rtl/core/rpp_out_if.sv */
`timescale 1ns / 1ps
interface rpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [15:0] meas_angle;
  logic               visible;

  modport source (output valid, meas_x, meas_y, meas_angle, visible, input ready);
  modport sink (input valid, meas_x, meas_y, meas_angle, visible, output ready);
endinterface

/* rtl/core/rpp_cfg_if.sv */
`timescale 1ns / 1ps
interface rpp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rpp_pkg::CFG_IDX_W-1:0]      index;
  logic [rpp_pkg::CFG_DAT_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/relative_planar_pose_measure.sv */
`timescale 1ns / 1ps
// Planar relative pose measurement.
// in_ch carries one transaction per pose pair: source pose, target pose and
// noise offsets. out_ch returns one transaction per input with the marker
// pose seen from the source camera, noise added, and a visible flag.
// cfg_ch writes the camera/marker mounts, visibility radius and the
// target-is-agent flag by register index; unknown indexes are dropped.
// cfg_ch is always ready; write it only while no transaction is in flight.
// Throughput: one transaction per cycle unless out_ch stalls. Three rotators
// run side by side, each a row of CORDIC cells, one iteration per cell.
// Register stages from acceptance to out_ch.valid: input (loaded at
// acceptance), prescale, quadrant, the iteration cells, sum,
// square/saturate, output.
// Backpressure: the whole pipeline holds while out_ch is stalled with a
// result waiting, and in_ch.ready drops in the same cycle.
// Reset (rst_n low, synchronous): all valid bits and config registers
// clear; data in flight is discarded.
module relative_planar_pose_measure (
  input  logic          clk,
  input  logic          rst_n,
  rpp_cfg_if.sink       cfg_ch,
  rpp_in_if.sink        in_ch,
  rpp_out_if.source     out_ch
);

  localparam int LAT = rpp_pkg::ROT_LAT;
  localparam int VW  = rpp_pkg::VW;
  localparam int XW  = rpp_pkg::XW;
  localparam int MW  = rpp_pkg::MW;

  // config registers
  logic signed [31:0] cam_x_r, cam_y_r, mrk_x_r, mrk_y_r;
  logic [15:0]        cam_a_r, mrk_a_r;
  logic [30:0]        radius_r;
  logic               agent_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      cam_a_r  <= '0;
      mrk_x_r  <= '0;
      mrk_y_r  <= '0;
      mrk_a_r  <= '0;
      radius_r <= '0;
      agent_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rpp_pkg::REG_CAMERA_X:     cam_x_r  <= cfg_ch.data;
        rpp_pkg::REG_CAMERA_Y:     cam_y_r  <= cfg_ch.data;
        rpp_pkg::REG_CAMERA_ANGLE: cam_a_r  <= cfg_ch.data[15:0];
        rpp_pkg::REG_MARKER_X:     mrk_x_r  <= cfg_ch.data;
        rpp_pkg::REG_MARKER_Y:     mrk_y_r  <= cfg_ch.data;
        rpp_pkg::REG_MARKER_ANGLE: mrk_a_r  <= cfg_ch.data[15:0];
        rpp_pkg::REG_VIS_RADIUS:   radius_r <= cfg_ch.data[30:0];
        rpp_pkg::REG_TARGET_AGENT: agent_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves when the output slot is free or taken
  logic out_valid_r;
  logic adv;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // valid bits: [0] input stage, [LAT] rotator outputs, [LAT+1] sum,
  // [LAT+2] square stage
  logic [LAT+2:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT+1:0], in_ch.valid};
      out_valid_r <= vld_r[LAT+2];
    end
  end

  // input stage: differences and composed angles
  logic signed [VW-1:0] dx_r, dy_r, kx_r, ky_r, cx_r, cy_r;
  logic [15:0]          a1_r, a2_r, a3_r;
  logic [15:0]          as_d_r [0:LAT];
  logic signed [31:0]   nx_d_r [0:LAT];
  logic signed [31:0]   ny_d_r [0:LAT];
  logic [15:0]          ang_out;

  always_comb begin
    ang_out = '0;
    if (agent_r) begin
      ang_out = in_ch.target_angle + mrk_a_r - in_ch.source_angle - cam_a_r
                + in_ch.noise_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r      <= VW'(in_ch.target_x) - VW'(in_ch.source_x);
      dy_r      <= VW'(in_ch.target_y) - VW'(in_ch.source_y);
      kx_r      <= VW'(mrk_x_r);
      ky_r      <= VW'(mrk_y_r);
      cx_r      <= VW'(cam_x_r);
      cy_r      <= VW'(cam_y_r);
      a1_r      <= 16'd0 - in_ch.source_angle - cam_a_r;
      a2_r      <= in_ch.target_angle - in_ch.source_angle - cam_a_r;
      a3_r      <= 16'd0 - cam_a_r;
      as_d_r[0] <= ang_out;
      nx_d_r[0] <= in_ch.noise_x;
      ny_d_r[0] <= in_ch.noise_y;
      for (int k = 1; k <= LAT; k++) begin
        as_d_r[k] <= as_d_r[k-1];
        nx_d_r[k] <= nx_d_r[k-1];
        ny_d_r[k] <= ny_d_r[k-1];
      end
    end
  end

  // three rotators: target offset, marker, camera mount
  logic signed [XW-1:0] x1, y1, x2, y2, x3, y3;

  rpp_rotator u_rot_tgt (
    .clk(clk), .en(adv), .x_in(dx_r), .y_in(dy_r), .ang_in(a1_r), .x_out(x1), .y_out(y1)
  );
  rpp_rotator u_rot_mrk (
    .clk(clk), .en(adv), .x_in(kx_r), .y_in(ky_r), .ang_in(a2_r), .x_out(x2), .y_out(y2)
  );
  rpp_rotator u_rot_cam (
    .clk(clk), .en(adv), .x_in(cx_r), .y_in(cy_r), .ang_in(a3_r), .x_out(x3), .y_out(y3)
  );

  // sum stage
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [31:0]   nx_s_r, ny_s_r;
  logic [15:0]          ang_s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r    <= MW'(x1) + MW'(x2) - MW'(x3);
      my_r    <= MW'(y1) + MW'(y2) - MW'(y3);
      nx_s_r  <= nx_d_r[LAT];
      ny_s_r  <= ny_d_r[LAT];
      ang_s_r <= as_d_r[LAT];
    end
  end

  // square stage: in-range check, squares, noise add with saturation
  logic                 inr_x, inr_y;
  logic signed [MW:0]   sx, sy;
  logic signed [31:0]   satx, saty;
  logic [63:0]          sqx_r, sqy_r;
  logic [61:0]          r2_r;
  logic                 inr_r;
  logic signed [31:0]   satx_r, saty_r;
  logic [15:0]          ang_q_r;

  function automatic logic signed [31:0] sat32(input logic signed [MW:0] v);
    logic signed [31:0] o;
    if (v > (MW+1)'(64'sd2147483647))       o = 32'sh7FFFFFFF;
    else if (v < -(MW+1)'(64'sd2147483648)) o = 32'sh80000000;
    else                                    o = v[31:0];
    return o;
  endfunction

  always_comb begin
    // strictly inside (-2^31, 2^31)
    inr_x = (mx_r[MW-1:31] == '0) || ((&mx_r[MW-1:31]) && (mx_r[30:0] != '0));
    inr_y = (my_r[MW-1:31] == '0) || ((&my_r[MW-1:31]) && (my_r[30:0] != '0));
    sx    = (MW+1)'(mx_r) + (MW+1)'(nx_s_r);
    sy    = (MW+1)'(my_r) + (MW+1)'(ny_s_r);
    satx  = sat32(sx);
    saty  = sat32(sy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r   <= 64'($signed(mx_r[31:0]) * $signed(mx_r[31:0]));
      sqy_r   <= 64'($signed(my_r[31:0]) * $signed(my_r[31:0]));
      r2_r    <= radius_r * radius_r;
      inr_r   <= inr_x && inr_y;
      satx_r  <= satx;
      saty_r  <= saty;
      ang_q_r <= ang_s_r;
    end
  end

  // output register
  logic signed [31:0] mxo_r, myo_r;
  logic [15:0]        ango_r;
  logic               viso_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mxo_r  <= satx_r;
      myo_r  <= saty_r;
      ango_r <= ang_q_r;
      viso_r <= inr_r && ((sqx_r + sqy_r) < 64'(r2_r));
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.meas_x     = mxo_r;
  assign out_ch.meas_y     = myo_r;
  assign out_ch.meas_angle = ango_r;
  assign out_ch.visible    = viso_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while result stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && (vld_r == '0))
    else $error("pipeline valid bits not cleared by reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted transaction not captured");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule

/* rtl/core/rpp_cordic_cell.sv */
`timescale 1ns / 1ps
module rpp_cordic_cell (
  input  logic                              clk,
  input  logic                              en,
  input  rpp_pkg::iter_t                    iter,
  input  logic signed [rpp_pkg::XW-1:0]     x_in,
  input  logic signed [rpp_pkg::XW-1:0]     y_in,
  input  logic signed [rpp_pkg::ZW-1:0]     z_in,
  output logic signed [rpp_pkg::XW-1:0]     x_out,
  output logic signed [rpp_pkg::XW-1:0]     y_out,
  output logic signed [rpp_pkg::ZW-1:0]     z_out
);

  logic signed [rpp_pkg::XW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [rpp_pkg::ZW-1:0] z_nxt, at;
  logic signed [rpp_pkg::XW-1:0] x_r, y_r;
  logic signed [rpp_pkg::ZW-1:0] z_r;

  always_comb begin
    dx = y_in >>> iter;
    dy = x_in >>> iter;
    at = rpp_pkg::atan_lut(iter);
    if (!z_in[rpp_pkg::ZW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - at;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

/* rtl/core/rpp_rotator.sv */
`timescale 1ns / 1ps
module rpp_rotator (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rpp_pkg::VW-1:0]     x_in,
  input  logic signed [rpp_pkg::VW-1:0]     y_in,
  input  logic [15:0]                       ang_in,
  output logic signed [rpp_pkg::XW-1:0]     x_out,
  output logic signed [rpp_pkg::XW-1:0]     y_out
);

  localparam int PW = rpp_pkg::VW + 25;

  logic signed [PW-1:0]          px, py;
  logic signed [rpp_pkg::XW-1:0] xp_r, yp_r;
  logic [15:0]                   ap_r;

  logic [15:0]                   a_bias, resid;
  logic [1:0]                    quad;
  logic signed [rpp_pkg::XW-1:0] xq_nxt, yq_nxt;
  logic signed [rpp_pkg::XW-1:0] xs [0:rpp_pkg::N_ITER];
  logic signed [rpp_pkg::XW-1:0] ys [0:rpp_pkg::N_ITER];
  logic signed [rpp_pkg::ZW-1:0] zs [0:rpp_pkg::N_ITER];
  logic signed [rpp_pkg::XW-1:0] xq_r, yq_r;
  logic signed [rpp_pkg::ZW-1:0] zq_r;

  // gain compensation, floor of product / 2^24
  assign px = PW'(x_in) * PW'(rpp_pkg::GAIN_Q24);
  assign py = PW'(y_in) * PW'(rpp_pkg::GAIN_Q24);

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r <= rpp_pkg::XW'($signed(px[PW-1:24]));
      yp_r <= rpp_pkg::XW'($signed(py[PW-1:24]));
      ap_r <= ang_in;
    end
  end

  // nearest quarter turn taken exactly, residual in [-8192, 8191]
  always_comb begin
    a_bias = ap_r + 16'd8192;
    quad   = a_bias[15:14];
    resid  = ap_r - {quad, 14'd0};
    case (quad)
      2'd1: begin
        xq_nxt = -yp_r;
        yq_nxt = xp_r;
      end
      2'd2: begin
        xq_nxt = -xp_r;
        yq_nxt = -yp_r;
      end
      2'd3: begin
        xq_nxt = yp_r;
        yq_nxt = -xp_r;
      end
      default: begin
        xq_nxt = xp_r;
        yq_nxt = yp_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xq_r <= xq_nxt;
      yq_r <= yq_nxt;
      zq_r <= {resid, 16'd0};
    end
  end

  assign xs[0] = xq_r;
  assign ys[0] = yq_r;
  assign zs[0] = zq_r;

  for (genvar i = 0; i < rpp_pkg::N_ITER; i++) begin : g_cell
    rpp_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .iter  (rpp_pkg::ITER_W'(i)),
      .x_in  (xs[i]),
      .y_in  (ys[i]),
      .z_in  (zs[i]),
      .x_out (xs[i+1]),
      .y_out (ys[i+1]),
      .z_out (zs[i+1])
    );
  end

  assign x_out = xs[rpp_pkg::N_ITER];
  assign y_out = ys[rpp_pkg::N_ITER];

endmodule
